/* hw/rtl/slsfp_pkg.sv */
// Shared types and constants for the sync/length/sum frame parser.
`timescale 1ns / 1ps
`default_nettype none

package slsfp_pkg;

  // Frame sync word
  localparam logic [7:0] SYNC_BYTE = 8'hAA;

  // Register map: index is byte address bit 2
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic REG_TIMEOUT     = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd255;
  localparam logic [15:0] TIMEOUT_RST     = 16'd1000;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_SYNC = 3'd0,
    PH_LEN  = 3'd1,
    PH_BODY = 3'd2,
    PH_CHK  = 3'd3,
    PH_TAIL = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]  max_payload;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] position;
    logic [7:0] frame_length;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/slsfp_if.sv */
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface slsfp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface slsfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic [7:0] position;
  logic [7:0] frame_length;

  modport source (output valid, output kind, output data, output position,
                  output frame_length, input ready);
  modport sink   (input valid, input kind, input data, input position,
                  input frame_length, output ready);
endinterface

`default_nettype wire

/* hw/rtl/slsfp_cfg.sv */
// APB configuration registers: max payload length and tick timeout.
`timescale 1ns / 1ps
`default_nettype none

module slsfp_cfg
  import slsfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  logic [7:0]  max_payload_q, max_payload_d;
  logic [15:0] timeout_q, timeout_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode write on the access phase
  always_comb begin
    max_payload_d = max_payload_q;
    timeout_d     = timeout_q;
    if (wr_en) begin
      case (paddr[2])
        REG_MAX_PAYLOAD: max_payload_d = pwdata[7:0];
        REG_TIMEOUT:     timeout_d     = pwdata[15:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
      timeout_q     <= TIMEOUT_RST;
    end else begin
      max_payload_q <= max_payload_d;
      timeout_q     <= timeout_d;
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_MAX_PAYLOAD: prdata = {24'd0, max_payload_q};
      REG_TIMEOUT:     prdata = {16'd0, timeout_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o.max_payload   = max_payload_q;
  assign cfg_o.timeout_ticks = timeout_q;

endmodule

`default_nettype wire

/* hw/rtl/slsfp_step.sv */
// Parser state and per-word step logic: phase, checksum, index, timeout.
`timescale 1ns / 1ps
`default_nettype none

module slsfp_step
  import slsfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_en_i,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  logic        active_q, active_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic [7:0]  sum_add;
  logic [7:0]  idx_inc;
  logic [15:0] elapsed_inc;
  logic        len_ok;
  logic        tick_expire;

  assign sum_add     = sum_q + rx_byte_i;
  assign idx_inc     = idx_q + 8'd1;
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign len_ok      = (rx_byte_i != 8'd0) && (rx_byte_i <= cfg_i.max_payload);
  assign tick_expire = elapsed_inc >= cfg_i.timeout_ticks;

  // Next state
  always_comb begin
    active_d  = active_q;
    phase_d   = phase_q;
    sum_d     = sum_q;
    idx_d     = idx_q;
    len_d     = len_q;
    elapsed_d = elapsed_q;
    if (opcode_i == OP_START) begin
      phase_d   = PH_SYNC;
      sum_d     = 8'd0;
      idx_d     = 8'd0;
      len_d     = 8'd0;
      elapsed_d = 16'd0;
      active_d  = (cfg_i.timeout_ticks != 16'd0);
    end else if (active_q && opcode_i == OP_TICK) begin
      elapsed_d = elapsed_inc;
      if (tick_expire) begin
        active_d = 1'b0;
        phase_d  = PH_SYNC;
      end
    end else if (active_q && opcode_i == OP_BYTE) begin
      case (phase_q)
        PH_LEN: begin
          len_d   = rx_byte_i;
          sum_d   = sum_add;
          idx_d   = 8'd0;
          phase_d = len_ok ? PH_BODY : PH_SYNC;
        end
        PH_BODY: begin
          sum_d = sum_add;
          idx_d = idx_inc;
          if (idx_inc == len_q) begin
            phase_d = PH_CHK;
          end
        end
        PH_CHK: begin
          phase_d = (rx_byte_i == sum_q) ? PH_TAIL : PH_SYNC;
        end
        PH_TAIL: begin
          active_d = 1'b0;
          phase_d  = PH_SYNC;
        end
        default: begin
          phase_d = PH_SYNC;
          if (rx_byte_i == SYNC_BYTE) begin
            sum_d   = rx_byte_i;
            phase_d = PH_LEN;
          end
        end
      endcase
    end
  end

  // Result word
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.kind         = KIND_BYTE;
    res_o.data         = 8'd0;
    res_o.position     = 8'd0;
    res_o.frame_length = 8'd0;
    if (opcode_i == OP_START) begin
      if (cfg_i.timeout_ticks == 16'd0) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_TIMEOUT;
      end
    end else if (active_q && opcode_i == OP_TICK) begin
      if (tick_expire) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_TIMEOUT;
      end
    end else if (active_q && opcode_i == OP_BYTE) begin
      case (phase_q)
        PH_BODY: begin
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_BYTE;
          res_o.data     = rx_byte_i;
          res_o.position = idx_q;
        end
        PH_TAIL: begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_DONE;
          res_o.frame_length = len_q;
        end
        default: ;
      endcase
    end
  end

  // Update state only on a word that moves through this stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      phase_q   <= PH_SYNC;
      sum_q     <= 8'd0;
      idx_q     <= 8'd0;
      len_q     <= 8'd0;
      elapsed_q <= 16'd0;
    end else if (step_en_i) begin
      active_q  <= active_d;
      phase_q   <= phase_d;
      sum_q     <= sum_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      elapsed_q <= elapsed_d;
    end
  end

`ifndef ASSERT_OFF
  a_body_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> idx_q < len_q)
    else $error("payload index reached frame length in body phase");

  a_idle_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> phase_q == PH_SYNC)
    else $error("idle parser left sync hunting");

  a_done_from_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_valid_o && res_o.kind == KIND_DONE |=> !active_q)
    else $error("parser still active after frame done");
`endif

endmodule

`default_nettype wire

/* hw/rtl/slsfp_obuf.sv */
// Result register driving the output channel.
`timescale 1ns / 1ps
`default_nettype none

module slsfp_obuf
  import slsfp_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire res_t          res_i,
  output logic               free_o,
  slsfp_out_if.source        out_if
);

  logic valid_q, valid_d;
  res_t res_q;

  // Slot is free when empty or draining this cycle
  assign free_o = !valid_q || out_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_if.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until a new word loads
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_if.valid        = valid_q;
  assign out_if.kind         = res_q.kind;
  assign out_if.data         = res_q.data;
  assign out_if.position     = res_q.position;
  assign out_if.frame_length = res_q.frame_length;

endmodule

`default_nettype wire

/* hw/rtl/sync_length_sum_frame_parser.sv */
// Top level of the sync/length/sum frame parser: input register, step, result register.
`timescale 1ns / 1ps
`default_nettype none

// Deframes sync 0xAA, length, payload, additive checksum and a trailing byte,
// one input word per cycle while the output channel keeps up. A word is
// captured in the input register, decoded by the step logic against the
// parser state, and any result is registered in the result register before
// it shows on the output channel. The input register advances whenever
// the result register is empty or being read, so the single result slot sets
// the throughput under output stalls. Registers: max_payload at address 0
// (reset 255), timeout_ticks at address 4 (reset 1000); write only while idle.
module sync_length_sum_frame_parser
  import slsfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  slsfp_in_if.sink                in_if,
  slsfp_out_if.source             out_if,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t       cfg;
  res_t       res;
  logic       res_valid;
  logic       obuf_free;
  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_op_q;
  logic [7:0] s1_byte_q;
  logic       s1_adv;
  logic       in_acc;

  slsfp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the input register when the result slot can take its word
  assign s1_adv       = s1_valid_q && obuf_free;
  assign in_if.ready  = !s1_valid_q || s1_adv;
  assign in_acc       = in_if.valid && in_if.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= in_if.opcode;
      s1_byte_q <= in_if.rx_byte;
    end
  end

  slsfp_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (s1_adv),
    .opcode_i    (s1_op_q),
    .rx_byte_i   (s1_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  slsfp_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_adv && res_valid),
    .res_i  (res),
    .free_o (obuf_free),
    .out_if (out_if)
  );

endmodule

`default_nettype wire
